/* sv/sphsa_pkg.sv */
`timescale 1ns / 1ps

package sphsa_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ID_DEPTH    = 1024;
  localparam int CLR_DEPTH   = (TABLE_DEPTH > ID_DEPTH) ? TABLE_DEPTH : ID_DEPTH;

  localparam int SLOT_W = $clog2(TABLE_DEPTH);
  localparam int ID_W   = $clog2(ID_DEPTH);
  localparam int SIZE_W = SLOT_W + 1;
  localparam int CLR_W  = $clog2(CLR_DEPTH);

  // Field widths of the interface words.
  localparam int FIELD_W    = 10;
  localparam int PASSED_W   = 10;
  localparam int TOTAL_W    = 64;
  localparam int STATUS_W   = 2;
  localparam int CFG_SIZE_W = 11;
  localparam int CFG_STEP_W = 10;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROBE_STEP = 1'd1;

  localparam logic [CFG_SIZE_W-1:0] TABLE_SIZE_RST = CFG_SIZE_W'(1024);
  localparam logic [CFG_STEP_W-1:0] PROBE_STEP_RST = CFG_STEP_W'(1);

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REMOVED  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN  = 2'd3;

  typedef struct packed {
    logic               operation;
    logic [FIELD_W-1:0] object_id;
    logic [FIELD_W-1:0] home_slot;
  } in_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FIELD_W-1:0]  chosen_slot;
    logic [PASSED_W-1:0] probes_passed;
    logic [TOTAL_W-1:0]  total_probes;
  } out_word_t;

endpackage

/* sv/stride_probe_hash_slot_allocator_core.sv */
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Word
// in_       input      in_valid / in_ready    operation, object_id, home_slot
// out_      output     out_valid / out_ready  status, chosen_slot, probes_passed, total_probes
// cfg_      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An insert reduces home slot and step by the table size in two bit-serial remainder units
// working side by side, then walks the occupancy memory one slot a cycle, counting the
// occupied slots passed. After reset a clearing pass zeroes the occupancy and id memories;
// no word is accepted meanwhile. Results wait in an output register, so a new word is
// taken while an earlier result is still pending; the block stalls only when a second
// result is ready.

module stride_probe_hash_slot_allocator_core (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  sphsa_pkg::in_word_t                    in_data,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output sphsa_pkg::out_word_t                   out_data,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [sphsa_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [sphsa_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_PROBE = 3'd3;
  localparam logic [2:0] S_REM   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  localparam int DIV_STEPS = sphsa_pkg::FIELD_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  // Memories: occupancy by slot, and {present, slot} by id.
  logic                      occ_mem [sphsa_pkg::TABLE_DEPTH];
  logic [sphsa_pkg::SLOT_W:0] idm_mem [sphsa_pkg::ID_DEPTH];

  logic                               occ_we, occ_wdata, occ_rdata_r;
  logic [sphsa_pkg::SLOT_W-1:0]       occ_waddr, occ_raddr;
  logic                               idm_we;
  logic [sphsa_pkg::SLOT_W:0]         idm_wdata, idm_rdata_r;
  logic [sphsa_pkg::ID_W-1:0]         idm_waddr, idm_raddr;

  logic [2:0]                         state_r, state_nxt;
  logic [sphsa_pkg::CLR_W-1:0]        clr_r, clr_nxt;
  logic [sphsa_pkg::CFG_SIZE_W-1:0]   table_size_r;
  logic [sphsa_pkg::CFG_STEP_W-1:0]   probe_step_r;
  logic [sphsa_pkg::FIELD_W-1:0]      id_r, id_nxt;
  logic [sphsa_pkg::FIELD_W-1:0]      home_r, home_nxt;
  logic [sphsa_pkg::SIZE_W-1:0]       size_r, size_nxt;
  logic [sphsa_pkg::SLOT_W-1:0]       step_r, step_nxt;
  logic [sphsa_pkg::SLOT_W-1:0]       cur_r, cur_nxt;
  logic [sphsa_pkg::SLOT_W-1:0]       home_mod_r, home_mod_nxt;
  logic [DCNT_W-1:0]                  dcnt_r, dcnt_nxt;
  logic [sphsa_pkg::PASSED_W-1:0]     skipped_r, skipped_nxt;
  logic [sphsa_pkg::TOTAL_W-1:0]      total_r, total_nxt;
  sphsa_pkg::out_word_t               res_r, res_nxt;
  logic                               out_valid_r, out_valid_nxt;
  sphsa_pkg::out_word_t               out_data_r, out_data_nxt;

  logic                               in_fire, out_load;
  logic [sphsa_pkg::SIZE_W-1:0]       eff_size;
  logic [sphsa_pkg::SLOT_W:0]         sh_home, sh_step, probe_sum;
  logic [sphsa_pkg::SLOT_W-1:0]       rem_home, rem_step, probe_next;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    if (table_size_r == '0) begin
      eff_size = sphsa_pkg::SIZE_W'(1);
    end else if (32'(table_size_r) > sphsa_pkg::TABLE_DEPTH) begin
      eff_size = sphsa_pkg::SIZE_W'(sphsa_pkg::TABLE_DEPTH);
    end else begin
      eff_size = sphsa_pkg::SIZE_W'(table_size_r);
    end
  end

  // One restoring remainder step for home slot and step each; the partial
  // remainder always stays below the table size.
  always_comb begin
    sh_home  = {cur_r, home_r[dcnt_r]};
    sh_step  = {step_r, probe_step_r[dcnt_r]};
    rem_home = (sh_home >= size_r) ? sphsa_pkg::SLOT_W'(sh_home - size_r)
                                   : sh_home[sphsa_pkg::SLOT_W-1:0];
    rem_step = (sh_step >= size_r) ? sphsa_pkg::SLOT_W'(sh_step - size_r)
                                   : sh_step[sphsa_pkg::SLOT_W-1:0];
    probe_sum  = {1'b0, cur_r} + {1'b0, step_r};
    probe_next = (probe_sum >= size_r) ? sphsa_pkg::SLOT_W'(probe_sum - size_r)
                                       : probe_sum[sphsa_pkg::SLOT_W-1:0];
  end

  always_comb begin
    state_nxt    = state_r;
    clr_nxt      = clr_r;
    id_nxt       = id_r;
    home_nxt     = home_r;
    size_nxt     = size_r;
    step_nxt     = step_r;
    cur_nxt      = cur_r;
    home_mod_nxt = home_mod_r;
    dcnt_nxt     = dcnt_r;
    skipped_nxt  = skipped_r;
    total_nxt    = total_r;
    res_nxt      = res_r;
    occ_we       = 1'b0;
    occ_waddr    = cur_r;
    occ_wdata    = 1'b0;
    idm_we       = 1'b0;
    idm_waddr    = id_r[sphsa_pkg::ID_W-1:0];
    idm_wdata    = '0;

    case (state_r)
      S_CLEAR: begin
        occ_we    = (32'(clr_r) < sphsa_pkg::TABLE_DEPTH);
        occ_waddr = clr_r[sphsa_pkg::SLOT_W-1:0];
        idm_we    = (32'(clr_r) < sphsa_pkg::ID_DEPTH);
        idm_waddr = clr_r[sphsa_pkg::ID_W-1:0];
        clr_nxt   = clr_r + 1'b1;
        if (32'(clr_r) == sphsa_pkg::CLR_DEPTH - 1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          id_nxt      = in_data.object_id;
          home_nxt    = in_data.home_slot;
          size_nxt    = eff_size;
          cur_nxt     = '0;
          step_nxt    = '0;
          skipped_nxt = '0;
          dcnt_nxt    = DCNT_W'(DIV_STEPS - 1);
          state_nxt   = (in_data.operation == sphsa_pkg::OP_REMOVE) ? S_REM : S_DIV;
        end
      end
      S_DIV: begin
        cur_nxt  = rem_home;
        step_nxt = rem_step;
        dcnt_nxt = dcnt_r - 1'b1;
        if (dcnt_r == '0) begin
          home_mod_nxt = rem_home;
          state_nxt    = S_PROBE;
        end
      end
      S_PROBE: begin
        // occ_rdata_r holds the occupancy of cur_r, read on the previous cycle.
        if (!occ_rdata_r) begin
          occ_we                = 1'b1;
          occ_wdata             = 1'b1;
          idm_we                = 1'b1;
          idm_wdata             = {1'b1, cur_r};
          total_nxt             = total_r + sphsa_pkg::TOTAL_W'(skipped_r);
          res_nxt.status        = sphsa_pkg::ST_INSERTED;
          res_nxt.chosen_slot   = sphsa_pkg::FIELD_W'(cur_r);
          res_nxt.probes_passed = skipped_r;
          res_nxt.total_probes  = total_r + sphsa_pkg::TOTAL_W'(skipped_r);
          state_nxt             = S_DONE;
        end else if (probe_next == home_mod_r) begin
          res_nxt.status        = sphsa_pkg::ST_FULL;
          res_nxt.chosen_slot   = '0;
          res_nxt.probes_passed = '0;
          res_nxt.total_probes  = total_r;
          state_nxt             = S_DONE;
        end else begin
          cur_nxt     = probe_next;
          skipped_nxt = skipped_r + 1'b1;
        end
      end
      S_REM: begin
        res_nxt.probes_passed = '0;
        res_nxt.total_probes  = total_r;
        if (idm_rdata_r[sphsa_pkg::SLOT_W]) begin
          occ_we              = 1'b1;
          occ_waddr           = idm_rdata_r[sphsa_pkg::SLOT_W-1:0];
          idm_we              = 1'b1;
          idm_wdata           = {1'b0, idm_rdata_r[sphsa_pkg::SLOT_W-1:0]};
          res_nxt.status      = sphsa_pkg::ST_REMOVED;
          res_nxt.chosen_slot = sphsa_pkg::FIELD_W'(idm_rdata_r[sphsa_pkg::SLOT_W-1:0]);
        end else begin
          res_nxt.status      = sphsa_pkg::ST_UNKNOWN;
          res_nxt.chosen_slot = '0;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Reads follow the next probe position and the next id, so the data is
    // in place on the cycle that needs it.
    occ_raddr = cur_nxt;
    idm_raddr = id_nxt[sphsa_pkg::ID_W-1:0];
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res_r;
    end else if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (occ_we) begin
      occ_mem[occ_waddr] <= occ_wdata;
    end
    occ_rdata_r <= occ_mem[occ_raddr];
  end

  always_ff @(posedge clk) begin
    if (idm_we) begin
      idm_mem[idm_waddr] <= idm_wdata;
    end
    idm_rdata_r <= idm_mem[idm_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_r        <= '0;
      total_r      <= '0;
      out_valid_r  <= 1'b0;
      table_size_r <= sphsa_pkg::TABLE_SIZE_RST;
      probe_step_r <= sphsa_pkg::PROBE_STEP_RST;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          sphsa_pkg::REG_TABLE_SIZE: table_size_r <= cfg_data[sphsa_pkg::CFG_SIZE_W-1:0];
          sphsa_pkg::REG_PROBE_STEP: probe_step_r <= cfg_data[sphsa_pkg::CFG_STEP_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    id_r       <= id_nxt;
    home_r     <= home_nxt;
    size_r     <= size_nxt;
    step_r     <= step_nxt;
    cur_r      <= cur_nxt;
    home_mod_r <= home_mod_nxt;
    dcnt_r     <= dcnt_nxt;
    skipped_r  <= skipped_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  // A slot is claimed only after its occupancy read came back free.
  a_claim_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PROBE && occ_we) |-> (!occ_rdata_r && occ_wdata))
    else $error("probe claimed an occupied slot");

  // The running total moves only on a successful insert.
  a_total_insert: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && total_r != $past(total_r)) |->
      ($past(state_r) == S_PROBE && !$past(occ_rdata_r)))
    else $error("probe total changed outside an insert");

  // Memories are written only by the clearing pass, a probe or a remove.
  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    (occ_we || idm_we) |->
      (state_r == S_CLEAR || state_r == S_PROBE || state_r == S_REM))
    else $error("memory written in an unexpected state");

  // No result can appear before the clearing pass is over.
  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> (!out_valid_r && !in_ready))
    else $error("activity during the clearing pass");

endmodule
